@@ src/quicksort_sorter_top_assert.svh @@
// Assertion macros used by the sorter top level.
// Depends on nothing; files include this by bare name.
`ifndef QUICKSORT_SORTER_TOP_ASSERT_SVH
`define QUICKSORT_SORTER_TOP_ASSERT_SVH

// Implication checked in the same cycle.
`define QSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define QSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/qss_pkg.sv @@
// Package for the quicksort sorter: sequencer state type.
// Depends on nothing.
package qss_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_POP_RD,
    ST_POP_CHK,
    ST_PIV_RD,
    ST_PIV,
    ST_U_RD,
    ST_U_CMP,
    ST_L_RD,
    ST_L_CMP,
    ST_PLACE,
    ST_PUSH_LO,
    ST_PUSH_HI,
    ST_OUT_RD,
    ST_OUT
  } qss_state_t;

endpackage

@@ src/qss_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module qss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/quicksort_sorter_top.sv @@
// Quick sort streaming sorter: top level with sequencer and two RAMs.
// Depends on qss_pkg, qss_ram and quicksort_sorter_top_assert.svh.
// Loading accepts one input beat per cycle; a beat without tlast gives nothing.
// On the tlast beat the set is sorted in place; every element compare is a
// RAM read state (U_RD or L_RD) followed by a compare state (U_CMP or L_CMP).
// Output reads each element from the element RAM before it offers the beat.
// Reset (rst_n, synchronous, active low) clears control state; RAMs are not cleared.
module quicksort_sorter_top #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] in_tdata,   // [DATA_WIDTH-1:0] value
  input  logic                                  in_tlast,   // last
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((DATA_WIDTH + 7) / 8) * 8-1:0] out_tdata,  // [DATA_WIDTH-1:0] sorted_value
  output logic                                  out_tlast,  // final_res
  output logic                                  out_tuser   // dropped
);

  import qss_pkg::*;

  localparam int TDW  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int IDXW = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1) > IDXW ? $clog2(CAPACITY + 1) : IDXW;

  // Sequencer state and counters.
  qss_state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r;      // elements held
  logic [CNTW-1:0] sp_r;       // pending ranges on the stack
  logic            ovf_r;      // an element was dropped in this set
  logic [CNTW-1:0] idx_r;      // output position

  // Partition working registers. The pivot value lives in pv_r; the store
  // entry at p_r is a hole that is filled with the pivot once the scan ends.
  logic [IDXW-1:0]       lb_r, ub_r, l_r, u_r, p_r;
  logic [DATA_WIDTH-1:0] pv_r;

  // RAM ports.
  logic                  st_we, st_re;
  logic [IDXW-1:0]       st_waddr, st_raddr;
  logic [DATA_WIDTH-1:0] st_wdata, st_rdata;
  logic                  sk_we, sk_re;
  logic [IDXW-1:0]       sk_waddr, sk_raddr;
  logic [2*IDXW-1:0]     sk_wdata, sk_rdata;

  // Derived conditions.
  logic            in_acc, out_acc, room, cmp_lt, cmp_gt, is_final, big_set;
  logic            push_lo, push_hi, stk_room;
  logic [CNTW-1:0] sp_dec;
  logic [IDXW-1:0] pop_lb, pop_ub, first_ub;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign room     = cnt_r < CNTW'(CAPACITY);
  assign cmp_lt   = $signed(st_rdata) < $signed(pv_r);
  assign cmp_gt   = $signed(st_rdata) > $signed(pv_r);
  assign is_final = (idx_r + 1'b1) == cnt_r;
  // Held count after this beat is at least two.
  assign big_set  = room ? (cnt_r != '0) : (CAPACITY > 1);
  assign first_ub = room ? cnt_r[IDXW-1:0] : IDXW'(CAPACITY - 1);
  assign push_lo  = {1'b0, p_r} > ({1'b0, lb_r} + 1'b1);
  assign push_hi  = ({1'b0, p_r} + 1'b1) < {1'b0, ub_r};
  assign stk_room = sp_r < CNTW'(CAPACITY);
  assign sp_dec   = sp_r - 1'b1;
  assign pop_lb   = sk_rdata[2*IDXW-1:IDXW];
  assign pop_ub   = sk_rdata[IDXW-1:0];

  // Element store: holds the set, sorted in place.
  qss_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Range stack: pending {low, high} index pairs.
  qss_ram #(.WIDTH(2 * IDXW), .DEPTH(CAPACITY)) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .re    (sk_re),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_tlast) begin
          state_nxt = big_set ? ST_POP_RD : ST_OUT_RD;
        end
      end
      ST_POP_RD:  state_nxt = (sp_r == '0) ? ST_OUT_RD : ST_POP_CHK;
      ST_POP_CHK: state_nxt = (pop_lb < pop_ub) ? ST_PIV_RD : ST_POP_RD;
      ST_PIV_RD:  state_nxt = ST_PIV;
      ST_PIV:     state_nxt = ST_U_RD;
      ST_U_RD:    state_nxt = (p_r == u_r) ? ST_PLACE : ST_U_CMP;
      ST_U_CMP:   state_nxt = cmp_lt ? ST_L_RD : ST_U_RD;
      ST_L_RD:    state_nxt = (p_r == l_r) ? ST_PLACE : ST_L_CMP;
      ST_L_CMP: begin
        if (!cmp_gt) begin
          state_nxt = ST_L_RD;
        end else begin
          state_nxt = (l_r < u_r) ? ST_U_RD : ST_PLACE;
        end
      end
      ST_PLACE:   state_nxt = ST_PUSH_LO;
      ST_PUSH_LO: state_nxt = ST_PUSH_HI;
      ST_PUSH_HI: state_nxt = ST_POP_RD;
      ST_OUT_RD:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          state_nxt = is_final ? ST_LOAD : ST_OUT_RD;
        end
      end
      default:    state_nxt = ST_LOAD;
    endcase
  end

  // Output and RAM control logic.
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    st_we      = 1'b0;
    st_waddr   = p_r;
    st_wdata   = st_rdata;
    st_re      = 1'b0;
    st_raddr   = u_r;
    sk_we      = 1'b0;
    sk_waddr   = sp_r[IDXW-1:0];
    sk_wdata   = {lb_r, IDXW'(p_r - 1'b1)};
    sk_re      = 1'b0;
    sk_raddr   = sp_dec[IDXW-1:0];
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        st_we     = in_acc && room;
        st_waddr  = cnt_r[IDXW-1:0];
        st_wdata  = in_tdata[DATA_WIDTH-1:0];
        // The whole set is the first pending range.
        sk_we     = in_acc && in_tlast && big_set;
        sk_waddr  = '0;
        sk_wdata  = {IDXW'(0), first_ub};
      end
      ST_POP_RD:  sk_re = (sp_r != '0);
      ST_PIV_RD: begin
        st_re    = 1'b1;
        st_raddr = lb_r;
      end
      ST_U_RD: begin
        st_re    = (p_r != u_r);
        st_raddr = u_r;
      end
      ST_U_CMP:   st_we = cmp_lt;
      ST_L_RD: begin
        st_re    = (p_r != l_r);
        st_raddr = l_r;
      end
      ST_L_CMP:   st_we = cmp_gt;
      ST_PLACE: begin
        st_we    = 1'b1;
        st_wdata = pv_r;
      end
      ST_PUSH_LO: sk_we = push_lo && stk_room;
      ST_PUSH_HI: begin
        sk_we    = push_hi && stk_room;
        sk_wdata = {IDXW'(p_r + 1'b1), ub_r};
      end
      ST_OUT_RD: begin
        st_re    = 1'b1;
        st_raddr = idx_r[IDXW-1:0];
      end
      ST_OUT:     out_tvalid = 1'b1;
      default:    in_tready = 1'b0;
    endcase
  end

  assign out_tdata = TDW'(st_rdata);
  assign out_tlast = is_final;
  assign out_tuser = ovf_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      sp_r    <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (room) begin
              cnt_r <= cnt_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_tlast && big_set) begin
              sp_r <= CNTW'(1);
            end
          end
        end
        ST_POP_RD: begin
          if (sp_r != '0) begin
            sp_r <= sp_dec;
          end
        end
        ST_PUSH_LO, ST_PUSH_HI: begin
          if (sk_we) begin
            sp_r <= sp_r + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_acc && is_final) begin
            cnt_r <= '0;
            sp_r  <= '0;
            ovf_r <= 1'b0;
          end
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  // Partition and output datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_POP_RD:  idx_r <= '0;
      ST_POP_CHK: begin
        lb_r <= pop_lb;
        ub_r <= pop_ub;
      end
      ST_PIV: begin
        pv_r <= st_rdata;
        l_r  <= lb_r;
        u_r  <= ub_r;
        p_r  <= lb_r;
      end
      ST_U_CMP: begin
        // Element below the pivot moves into the hole; the hole moves to u.
        if (cmp_lt) begin
          p_r <= u_r;
        end else begin
          u_r <= u_r - 1'b1;
        end
      end
      ST_L_CMP: begin
        if (cmp_gt) begin
          p_r <= l_r;
        end else begin
          l_r <= l_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      default: begin
        idx_r <= (state_r == ST_LOAD) ? '0 : idx_r;
      end
    endcase
  end

  `include "quicksort_sorter_top_assert.svh"

  `QSS_ASSERT_NOW(a_stack_empty_load, in_tready, sp_r == '0, "range stack not empty while loading")
  `QSS_ASSERT_NOW(a_out_nonempty, out_tvalid, cnt_r != '0 && idx_r < cnt_r, "output beyond held set")
  `QSS_ASSERT_NEXT(a_no_load_mid_run, out_acc && !out_tlast, !in_tready, "input taken mid run")

endmodule

@@ tb/quicksort_sorter_top_tb.sv @@
// Testbench for the quicksort streaming sorter: loads sets of signed values,
// predicts the ascending output with a local sort, and checks every beat.
// Depends on quicksort_sorter_top and nothing else.
`timescale 1ns / 100ps

module quicksort_sorter_top_tb;

  localparam int CAPACITY = 32;
  localparam int DATA_WIDTH = 32;
  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic                  final_beat;
    logic                  dropped;
  } sorted_beat_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic                  last;
  } element_beat_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic               in_tlast;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tlast;
  logic               out_tuser;

  quicksort_sorter_top #(
    .CAPACITY(CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser)
  );

  // Predictor state: the set being collected and whether any element was lost.
  logic signed [DATA_WIDTH-1:0] held_set[$];
  logic                         set_overflow;
  sorted_beat_t                 sorted_expect[$];

  int mismatch_count;
  int checked_beats;
  int sets_done;
  int overflow_sets;
  bit hold_off;

  // Directed table; rows with a typed expectation are checked against it as well.
  typedef struct {
    element_beat_t beat;
    bit            has_typed;
    sorted_beat_t  typed;
  } dir_row_t;
  dir_row_t directed_rows[$];
  sorted_beat_t typed_expect[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Accepts one input beat into the predictor; on a last beat the held set is
  // sorted ascending (signed) and queued as expected output beats.
  task automatic collect_element(input element_beat_t b);
    logic signed [DATA_WIDTH-1:0] tmp;
    int n;
    if (held_set.size() < CAPACITY) begin
      held_set.push_back(b.value);
    end else begin
      set_overflow = 1'b1;
    end
    if (b.last) begin
      n = held_set.size();
      for (int i = 1; i < n; i++) begin
        for (int j = i; j > 0 && held_set[j-1] > held_set[j]; j--) begin
          tmp = held_set[j];
          held_set[j] = held_set[j-1];
          held_set[j-1] = tmp;
        end
      end
      for (int i = 0; i < n; i++) begin
        sorted_expect.push_back('{held_set[i], (i == n - 1), set_overflow});
      end
      if (set_overflow) overflow_sets++;
      sets_done++;
      held_set.delete();
      set_overflow = 1'b0;
    end
  endtask

  // Offers one beat, possibly after a random gap, and waits until it is taken.
  // Valid stays high afterwards; the next beat or the end of stimulus drops it.
  task automatic send_element(input element_beat_t b, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= TDATA_W'(b.value);
    in_tlast <= b.last;
    do @(posedge clk); while (!in_tready);
    collect_element(b);
  endtask

  // Sends a burst stream: gaps only between bursts, so valid stays high within one.
  task automatic send_set(input element_beat_t beats[$]);
    int burst_left;
    burst_left = 0;
    foreach (beats[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        send_element(beats[i], ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end else begin
        send_element(beats[i], 0);
      end
      burst_left--;
    end
  endtask

  function automatic logic [DATA_WIDTH-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2: return DATA_WIDTH'($urandom_range(0, 7)) - DATA_WIDTH'(3);
      default: return DATA_WIDTH'($urandom());
    endcase
  endfunction

  // Receiver: ready follows a pattern of its own, with stall-free stretches and
  // one long hold-off requested by the stimulus.
  initial begin
    int phase;
    out_tready = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if ((phase / 64) % 3 == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Output checker: every accepted beat is compared to the oldest expectation.
  always @(posedge clk) begin
    sorted_beat_t want;
    sorted_beat_t got;
    sorted_beat_t typed_want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[DATA_WIDTH-1:0], out_tlast, out_tuser};
      if (sorted_expect.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected output beat: value %0d last %0b dropped %0b",
                   $signed(got.value), got.final_beat, got.dropped);
      end else begin
        want = sorted_expect.pop_front();
        checked_beats++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     $signed(want.value), want.final_beat, want.dropped,
                     $signed(got.value), got.final_beat, got.dropped);
        end
        if (typed_expect.size() > 0) begin
          typed_want = typed_expect.pop_front();
          if (got !== typed_want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Directed row mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                       $signed(typed_want.value), typed_want.final_beat,
                       typed_want.dropped, $signed(got.value), got.final_beat,
                       got.dropped);
          end
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #50ms;
    $display("Timeout while waiting for output beats");
    $display("Some tests failed");
    $finish;
  end

  initial begin
    element_beat_t set_beats[$];
    int total_items;
    int set_len;
    int drain;
    held_set.delete();
    set_overflow = 1'b0;
    mismatch_count = 0;
    checked_beats = 0;
    sets_done = 0;
    overflow_sets = 0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a single-element set with the most negative value, a
    // two-element set with both extremes in reverse order, and a set with
    // repeated values. Expectations here are obvious, so they are typed in.
    directed_rows.push_back('{'{32'h8000_0000, 1'b1}, 1, '{32'h8000_0000, 1'b1, 1'b0}});
    directed_rows.push_back('{'{32'h7fff_ffff, 1'b0}, 1, '{32'h8000_0000, 1'b0, 1'b0}});
    directed_rows.push_back('{'{32'h8000_0000, 1'b1}, 1, '{32'h7fff_ffff, 1'b1, 1'b0}});
    directed_rows.push_back('{'{32'h0000_0005, 1'b0}, 1, '{32'hffff_ffff, 1'b0, 1'b0}});
    directed_rows.push_back('{'{32'hffff_ffff, 1'b0}, 1, '{32'h0000_0005, 1'b0, 1'b0}});
    directed_rows.push_back('{'{32'h0000_0005, 1'b1}, 1, '{32'h0000_0005, 1'b1, 1'b0}});
    set_beats.delete();
    foreach (directed_rows[i]) begin
      set_beats.push_back(directed_rows[i].beat);
      if (directed_rows[i].has_typed) typed_expect.push_back(directed_rows[i].typed);
    end
    send_set(set_beats);

    // Overflow set: 34 descending values; the last two beats are dropped.
    set_beats.delete();
    for (int i = 0; i < CAPACITY + 2; i++)
      set_beats.push_back('{DATA_WIDTH'(CAPACITY - i), (i == CAPACITY + 1)});
    send_set(set_beats);
    total_items = 6 + CAPACITY + 2;

    // Random sets. Mostly small sets, a few full or overflowing ones. Once, the
    // receiver holds off for a long stretch while a full set is offered.
    while (total_items < 430) begin
      case ($urandom_range(0, 9))
        0: set_len = $urandom_range(CAPACITY, CAPACITY + 3);
        1: set_len = 1;
        default: set_len = $urandom_range(2, 12);
      endcase
      set_beats.delete();
      for (int i = 0; i < set_len; i++)
        set_beats.push_back('{random_value(), (i == set_len - 1)});
      if (sets_done == 6) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (600) @(posedge clk);
            hold_off = 1'b0;
          end
          begin
            send_set(set_beats);
            set_beats.delete();
            for (int i = 0; i < CAPACITY; i++)
              set_beats.push_back('{random_value(), (i == CAPACITY - 1)});
            send_set(set_beats);
          end
        join
        total_items += set_len + CAPACITY;
      end else begin
        send_set(set_beats);
        total_items += set_len;
      end
    end
    in_tvalid <= 1'b0;

    drain = 0;
    while (sorted_expect.size() > 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);

    $display("Covered %0d sets (%0d with overflow), %0d output beats checked.",
             sets_done, overflow_sets, checked_beats);
    if (mismatch_count == 0 && sorted_expect.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d beats still expected", mismatch_count,
               sorted_expect.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
